FILE: design/egrd_pkg.sv
// egrd_pkg: shared types and constants for the Elias gamma run-length bit decoder.
// No dependencies; every design file refers to it by scoped names.
package egrd_pkg;

  // Longest zero prefix that still starts a valid codeword
  localparam logic [2:0] MAX_PREFIX = 3'd7;

  // Command queue between parser and bit packer
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef struct packed {
    logic code_bit;
    logic end_of_code;
  } code_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] valid_bits;
    logic       prefix_error;
    logic       last_of_run;
  } dec_word_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_RUN,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] len;
    logic       eoc;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ERR,
    BK_RUN,
    BK_FLUSH
  } back_state_t;

endpackage

FILE: design/egrd_front.sv
// egrd_front: codeword parser. Takes code bits, emits run / error / end commands.
// Depends on egrd_pkg.
module egrd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                code_valid,
  output logic                code_stall,
  input  egrd_pkg::code_word_t code_word,
  input  logic                q_full,
  output logic                push,
  output egrd_pkg::cmd_t      push_cmd
);

  logic       reading_value, reading_value_next;
  logic [2:0] zero_count, zero_count_next;
  logic [2:0] bits_left, bits_left_next;
  logic [7:0] run_value, run_value_next;
  logic       take;
  logic [7:0] rv_shift;
  logic [2:0] bl_dec;

  // Stall whenever the queue has no room; a bit may need a slot
  assign code_stall = q_full;
  assign take       = code_valid && !q_full;

  assign rv_shift = {run_value[6:0], code_word.code_bit};
  assign bl_dec   = (bits_left != 3'd0) ? bits_left - 3'd1 : 3'd0;

  always_comb begin
    reading_value_next = reading_value;
    zero_count_next    = zero_count;
    bits_left_next     = bits_left;
    run_value_next     = run_value;
    push_cmd.kind      = egrd_pkg::CMD_NONE;
    push_cmd.len       = 8'd0;
    push_cmd.eoc       = code_word.end_of_code;

    if (!reading_value) begin
      if (!code_word.code_bit) begin
        if (zero_count >= egrd_pkg::MAX_PREFIX) begin
          push_cmd.kind   = egrd_pkg::CMD_ERR;
          zero_count_next = 3'd0;
        end else begin
          zero_count_next = zero_count + 3'd1;
        end
      end else if (zero_count == 3'd0) begin
        push_cmd.kind = egrd_pkg::CMD_RUN;
        push_cmd.len  = 8'd1;
      end else begin
        reading_value_next = 1'b1;
        run_value_next     = 8'd1;
        bits_left_next     = zero_count;
      end
    end else begin
      run_value_next = rv_shift;
      bits_left_next = bl_dec;
      if (bl_dec == 3'd0) begin
        push_cmd.kind      = egrd_pkg::CMD_RUN;
        push_cmd.len       = rv_shift;
        reading_value_next = 1'b0;
        zero_count_next    = 3'd0;
        run_value_next     = 8'd0;
      end
    end

    // end of code drops any half-parsed codeword
    if (code_word.end_of_code) begin
      reading_value_next = 1'b0;
      zero_count_next    = 3'd0;
      bits_left_next     = 3'd0;
      run_value_next     = 8'd0;
    end
  end

  assign push = take && ((push_cmd.kind != egrd_pkg::CMD_NONE) || code_word.end_of_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_value <= 1'b0;
      zero_count    <= 3'd0;
      bits_left     <= 3'd0;
      run_value     <= 8'd0;
    end else if (take) begin
      reading_value <= reading_value_next;
      zero_count    <= zero_count_next;
      bits_left     <= bits_left_next;
      run_value     <= run_value_next;
    end
  end

endmodule

FILE: design/egrd_cmd_fifo.sv
// egrd_cmd_fifo: small command queue between parser and packer.
// Depends on egrd_pkg.
module egrd_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  egrd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output egrd_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  egrd_pkg::cmd_t                  mem [egrd_pkg::CMDQ_DEPTH];
  logic [egrd_pkg::CMDQ_PTR_W-1:0] wr_ptr;
  logic [egrd_pkg::CMDQ_PTR_W-1:0] rd_ptr;
  logic [egrd_pkg::CMDQ_CNT_W-1:0] count;

  assign full  = (count == egrd_pkg::CMDQ_CNT_W'(egrd_pkg::CMDQ_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == egrd_pkg::CMDQ_PTR_W'(egrd_pkg::CMDQ_DEPTH - 1)) ?
                  '0 : wr_ptr + egrd_pkg::CMDQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == egrd_pkg::CMDQ_PTR_W'(egrd_pkg::CMDQ_DEPTH - 1)) ?
                  '0 : rd_ptr + egrd_pkg::CMDQ_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + egrd_pkg::CMDQ_CNT_W'(1);
        2'b01:   count <= count - egrd_pkg::CMDQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("cmd queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("cmd queue pop while empty");

endmodule

FILE: design/egrd_back.sv
// egrd_back: bit packer. Expands run commands into bytes, flushes, holds output register.
// Depends on egrd_pkg.
module egrd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  egrd_pkg::cmd_t      head,
  output logic                pop,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  output logic                dec_valid,
  input  logic                dec_stall,
  output egrd_pkg::dec_word_t dec_word
);

  egrd_pkg::back_state_t state, state_next;
  logic [7:0] rem, rem_next;
  logic       eoc, eoc_next;
  logic       run_bit, run_bit_next;
  logic       start_bit;
  logic [7:0] acc, acc_next;
  logic [2:0] fill, fill_next;

  logic                out_free;
  logic                emit;
  egrd_pkg::dec_word_t emit_word;

  logic [3:0] room;
  logic [3:0] k;
  logic [3:0] fill_sum;
  logic [7:0] acc_step;
  logic [7:0] rem_left;

  assign out_free  = !dec_valid || !dec_stall;
  assign cfg_ready = (state == egrd_pkg::BK_IDLE) && q_empty;

  // bits that fit in the current byte this cycle
  assign room     = 4'd8 - {1'b0, fill};
  assign k        = (rem < {4'd0, room}) ? rem[3:0] : room;
  assign fill_sum = {1'b0, fill} + k;
  assign acc_step = (acc << k) | (run_bit ? ~(8'hFF << k) : 8'h00);
  assign rem_left = rem - {4'd0, k};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egrd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    rem_next     = rem;
    eoc_next     = eoc;
    run_bit_next = run_bit;
    acc_next     = acc;
    fill_next    = fill;
    pop          = 1'b0;
    emit         = 1'b0;
    emit_word    = '0;

    case (state)
      egrd_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          rem_next = head.len;
          eoc_next = head.eoc;
          case (head.kind)
            egrd_pkg::CMD_ERR: state_next = egrd_pkg::BK_ERR;
            egrd_pkg::CMD_RUN: state_next = egrd_pkg::BK_RUN;
            default:           state_next = egrd_pkg::BK_FLUSH;
          endcase
        end
      end

      egrd_pkg::BK_ERR: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_word.prefix_error = 1'b1;
          emit_word.last_of_run  = !(eoc && (fill != 3'd0));
          state_next = eoc ? egrd_pkg::BK_FLUSH : egrd_pkg::BK_IDLE;
        end
      end

      egrd_pkg::BK_RUN: begin
        if (out_free) begin
          rem_next = rem_left;
          if (fill_sum == 4'd8) begin
            emit                  = 1'b1;
            emit_word.out_byte    = acc_step;
            emit_word.valid_bits  = 4'd8;
            // last only if no further full byte and no flush follows
            emit_word.last_of_run = (rem_left < 8'd8) && !(eoc && (rem_left != 8'd0));
            acc_next  = 8'd0;
            fill_next = 3'd0;
          end else begin
            acc_next  = acc_step;
            fill_next = fill_sum[2:0];
          end
          if (rem_left == 8'd0) begin
            run_bit_next = !run_bit;
            state_next   = eoc ? egrd_pkg::BK_FLUSH : egrd_pkg::BK_IDLE;
          end
        end
      end

      egrd_pkg::BK_FLUSH: begin
        if (out_free) begin
          if (fill != 3'd0) begin
            emit                  = 1'b1;
            emit_word.out_byte    = acc;
            emit_word.valid_bits  = {1'b0, fill};
            emit_word.last_of_run = 1'b1;
          end
          acc_next     = 8'd0;
          fill_next    = 3'd0;
          run_bit_next = start_bit;
          state_next   = egrd_pkg::BK_IDLE;
        end
      end

      default: state_next = egrd_pkg::BK_IDLE;
    endcase

    // a start_bit write reloads the run bit at once
    if (cfg_valid && cfg_ready) begin
      run_bit_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= 8'd0;
      eoc       <= 1'b0;
      run_bit   <= 1'b0;
      start_bit <= 1'b0;
      acc       <= 8'd0;
      fill      <= 3'd0;
    end else begin
      rem     <= rem_next;
      eoc     <= eoc_next;
      run_bit <= run_bit_next;
      acc     <= acc_next;
      fill    <= fill_next;
      if (cfg_valid && cfg_ready) begin
        start_bit <= cfg_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (out_free) begin
      dec_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      dec_word <= emit_word;
    end
  end

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == egrd_pkg::BK_RUN) |-> (rem != 8'd0))
    else $error("run state with nothing left to emit");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == egrd_pkg::BK_FLUSH && out_free) |=> (fill == 3'd0 && state == egrd_pkg::BK_IDLE))
    else $error("flush did not clear the partial byte");
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    (dec_valid && dec_word.prefix_error) |-> (dec_word.valid_bits == 4'd0))
    else $error("error result carries data bits");

endmodule

FILE: design/elias_gamma_rle_bit_decoder.sv
// elias_gamma_rle_bit_decoder: top level; parser, command queue and bit packer.
// Depends on egrd_pkg, egrd_front, egrd_cmd_fifo, egrd_back.
//
//  channel | handshake            | word
//  --------+----------------------+---------------------------------------------
//  code    | code_valid/code_stall| code_bit, end_of_code
//  dec     | dec_valid/dec_stall  | out_byte, valid_bits, prefix_error, last_of_run
//  cfg     | cfg_valid/cfg_ready  | start_bit
//
// Code bits are taken one per cycle while the 2-entry command queue has room.
// The packer pops a command in its idle state, then packs up to 8 bits into
// the current byte per step until the run is used up; an error word is
// emitted in the state after the pop, and end of code adds a flush state.
// Runs reach 255 bits; the queue lets the parser go on while the packer
// expands a run, and the packer loop sets the rate.
// Reset (rst, synchronous) clears the parser, queue, packer and start_bit.
// dec_stall only holds the output register and, through it, the packer;
// cfg_ready is high only while the packer is idle and the queue is empty.
module elias_gamma_rle_bit_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                code_valid,
  output logic                code_stall,
  input  egrd_pkg::code_word_t code_word,
  output logic                dec_valid,
  input  logic                dec_stall,
  output egrd_pkg::dec_word_t dec_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  egrd_pkg::cmd_t push_cmd;
  egrd_pkg::cmd_t head;

  // parser: classifies each code bit, queues a command per finished codeword
  egrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_word  (code_word),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // decouples the parser from long run expansions
  egrd_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // packer: run bit, byte accumulator, output register, start_bit register
  egrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec_word  (dec_word)
  );

endmodule
